FILE: rtl/core/lfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared constants, types and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
package lfo_pkg;

  localparam int PHASE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int TS_W      = 32;
  localparam int RATE_W    = 12;
  localparam int DEPTH_W   = 15;
  localparam int WAVE_W    = 2;
  localparam int LEVEL_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  localparam int PH_W      = 24;
  localparam int SINE_W    = 15;
  localparam int SINE_FRAC = 15;
  localparam int OPD_W     = PH_W + 1;
  localparam int PROD_W    = DEPTH_W + 1 + OPD_W;

  localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int QIDX_W      = SINE_TABLE_BITS - 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAWTOOTH = 2'd2
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE  = 2'd0,
    CFG_RATE  = 2'd1,
    CFG_DEPTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic              valid;
    logic [WAVE_W-1:0] wave;
  } lfo_ctl_t;

  typedef logic [SINE_W-1:0] sine_tab_t [0:QUARTER_LEN];

  localparam logic [63:0] C1  = 64'd1686629713;
  localparam logic [63:0] C3  = 64'd693598668;
  localparam logic [63:0] C5  = 64'd85569305;
  localparam logic [63:0] C7  = 64'd5026995;
  localparam logic [63:0] C9  = 64'd172272;
  localparam logic [63:0] C11 = 64'd3864;

  // Quarter-wave sine in unsigned Q0.15 from an odd Taylor series evaluated in Q30.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      u  = 64'(k) << (30 - (SINE_TABLE_BITS - 2));
      u2 = (u * u) >> 30;
      r  = C11;
      r  = C9 - ((r * u2) >> 30);
      r  = C7 - ((r * u2) >> 30);
      r  = C5 - ((r * u2) >> 30);
      r  = C3 - ((r * u2) >> 30);
      r  = C1 - ((r * u2) >> 30);
      r  = (r * u) >> 30;
      v  = (r * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = SINE_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine();

endpackage
`default_nettype wire

FILE: rtl/core/lfo_phase.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_phase
// Registers the timestamp, then forms the phase from timestamp times rate.
// ----------------------------------------------------------------------------
module lfo_phase (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [lfo_pkg::TS_W-1:0]        timestamp,
  input  wire logic [lfo_pkg::WAVE_W-1:0]      wave_select,
  input  wire logic [lfo_pkg::RATE_W-1:0]      rate_hz,
  output lfo_pkg::lfo_ctl_t                    phase_ctl,
  output logic      [lfo_pkg::PHASE_BITS-1:0]  phase
);
  import lfo_pkg::*;

  lfo_ctl_t              in_ctl;
  logic [PHASE_BITS-1:0] ts_low;
  logic [PHASE_BITS-1:0] phase_next;

  // Only the low phase bits of the timestamp reach the wrapped product.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl.valid <= 1'b0;
    end else begin
      in_ctl.valid <= start;
    end
    in_ctl.wave <= wave_select;
    ts_low      <= timestamp[PHASE_BITS-1:0];
  end

  assign phase_next = ts_low * PHASE_BITS'(rate_hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ctl.valid <= 1'b0;
    end else begin
      phase_ctl.valid <= in_ctl.valid;
    end
    phase_ctl.wave <= in_ctl.wave;
    phase          <= phase_next;
  end

endmodule
`default_nettype wire

FILE: rtl/core/lfo_shape.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_shape
// Turns the phase into the signed waveform value that depth will scale.
// ----------------------------------------------------------------------------
module lfo_shape (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lfo_pkg::lfo_ctl_t                   phase_ctl,
  input  wire logic        [lfo_pkg::PHASE_BITS-1:0] phase,
  output lfo_pkg::lfo_ctl_t                        shape_ctl,
  output logic signed      [lfo_pkg::OPD_W-1:0]    operand
);
  import lfo_pkg::*;

  logic        [PH_W-1:0]            ph;
  logic        [SINE_TABLE_BITS-1:0] idx;
  logic        [1:0]                 quad;
  logic        [QIDX_W-1:0]          q;
  logic        [QIDX_W-1:0]          tab_idx;
  logic signed [OPD_W-1:0]           sine_mag;
  logic signed [OPD_W-1:0]           s_ext;
  logic signed [OPD_W-1:0]           operand_next;

  assign ph   = PH_W'(phase) << (PH_W - PHASE_BITS);
  assign idx  = ph[PH_W-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign q    = QIDX_W'(idx[SINE_TABLE_BITS-3:0]);

  assign tab_idx  = quad[0] ? (QIDX_W'(QUARTER_LEN) - q) : q;
  assign sine_mag = {{(OPD_W-SINE_W){1'b0}}, SINE_TABLE[tab_idx]};
  assign s_ext    = {ph[PH_W-1], ph};

  always_comb begin
    case (phase_ctl.wave)
      WAVE_SINE:     operand_next = quad[1] ? -sine_mag : sine_mag;
      WAVE_TRIANGLE: operand_next = s_ext[OPD_W-1] ? -s_ext : s_ext;
      WAVE_SAWTOOTH: operand_next = s_ext;
      default:       operand_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_ctl.valid <= 1'b0;
    end else begin
      shape_ctl.valid <= phase_ctl.valid;
    end
    shape_ctl.wave <= phase_ctl.wave;
    operand        <= operand_next;
  end

endmodule
`default_nettype wire

FILE: rtl/core/lfo_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_scale
// Multiplies the waveform value by depth and shifts it down to the level.
// ----------------------------------------------------------------------------
module lfo_scale (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lfo_pkg::lfo_ctl_t                 shape_ctl,
  input  wire logic signed [lfo_pkg::OPD_W-1:0]  operand,
  input  wire logic        [lfo_pkg::DEPTH_W-1:0] depth,
  output logic                                   done,
  output logic signed      [lfo_pkg::LEVEL_W-1:0] level
);
  import lfo_pkg::*;

  lfo_ctl_t                   prod_ctl;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [LEVEL_W-1:0]  level_next;

  assign prod_next = $signed({1'b0, depth}) * operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl.valid <= 1'b0;
    end else begin
      prod_ctl.valid <= shape_ctl.valid;
    end
    prod_ctl.wave <= shape_ctl.wave;
    prod          <= prod_next;
  end

  always_comb begin
    case (prod_ctl.wave)
      WAVE_SINE:     level_next = LEVEL_W'(prod >>> SINE_FRAC);
      WAVE_TRIANGLE: level_next = LEVEL_W'(prod >>> PH_W);
      WAVE_SAWTOOTH: level_next = LEVEL_W'(prod >>> PH_W);
      default:       level_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_ctl.valid;
    end
    level <= level_next;
  end

endmodule
`default_nettype wire

FILE: rtl/core/lfo_waveform_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Low-frequency oscillator giving sine, triangle or sawtooth samples from a
// timestamp, scaled by a programmable depth.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. Each
// item passes through five register stages (timestamp capture, phase multiply,
// waveform shaping with the sine table, depth multiply, output shift), and its
// level appears with done from the output shift register. The result is held for
// exactly one cycle and the receiver cannot stall it. Configuration writes are
// always ready and should only be made while no item is in flight.
module lfo_waveform_generator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [lfo_pkg::TS_W-1:0]      timestamp,
  output logic                                     done,
  output logic signed      [lfo_pkg::LEVEL_W-1:0]   level,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [lfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [lfo_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lfo_pkg::*;

  logic [WAVE_W-1:0]     wave_select;
  logic [RATE_W-1:0]     rate_hz;
  logic [DEPTH_W-1:0]    depth;
  lfo_ctl_t              phase_ctl;
  logic [PHASE_BITS-1:0] phase;
  lfo_ctl_t              shape_ctl;
  logic signed [OPD_W-1:0] operand;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select <= WAVE_SINE;
      rate_hz     <= RATE_RESET;
      depth       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WAVE:  wave_select <= cfg_data[WAVE_W-1:0];
        CFG_RATE:  rate_hz     <= cfg_data[RATE_W-1:0];
        CFG_DEPTH: depth       <= cfg_data[DEPTH_W-1:0];
        default:   ;
      endcase
    end
  end

  lfo_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .timestamp   (timestamp),
    .wave_select (wave_select),
    .rate_hz     (rate_hz),
    .phase_ctl   (phase_ctl),
    .phase       (phase)
  );

  lfo_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .phase_ctl (phase_ctl),
    .phase     (phase),
    .shape_ctl (shape_ctl),
    .operand   (operand)
  );

  lfo_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .shape_ctl (shape_ctl),
    .operand   (operand),
    .depth     (depth),
    .done      (done),
    .level     (level)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the low-frequency oscillator. Timestamps are driven
// in bursts from a queue, each accepted item is predicted in sine, triangle or
// sawtooth form from a private copy of the registers and sine table, and every
// level strobed out is compared in order with its prediction.
// ----------------------------------------------------------------------------
module tb;
  import lfo_pkg::*;

  localparam logic [WAVE_W-1:0]    WAVE_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;
  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam int                   RANDOM_PHASES  = 21;
  localparam int                   PHASE_ITEMS    = 50;

  typedef struct {
    logic [TS_W-1:0]           ts;
    logic signed [LEVEL_W-1:0] level;
  } lfo_sample_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [TS_W-1:0]             timestamp = '0;
  logic                        done;
  logic signed [LEVEL_W-1:0]   level;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_WAVE;
  logic [CFG_DAT_W-1:0]        cfg_data = '0;

  logic [WAVE_W-1:0]           wave_sel = WAVE_SINE;
  logic [RATE_W-1:0]           rate_cfg = RATE_RESET;
  logic [DEPTH_W-1:0]          depth_cfg = '0;
  longint                      quarter_sine [0:QUARTER_LEN];

  logic [TS_W-1:0]             ts_queue [$];
  lfo_sample_t                 levels_due [$];
  bit                          item_taken = 1'b0;
  bit                          reg_taken = 1'b0;
  bit                          burst_gaps = 1'b1;
  int                          burst_left = 0;
  int                          gap_left = 0;
  int                          quiet_cycles = 0;
  int                          mismatches = 0;

  lfo_waveform_generator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .timestamp (timestamp),
    .done      (done),
    .level     (level),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [LEVEL_W-1:0] lfo_level(input logic [TS_W-1:0] ts);
    logic [63:0]           prod;
    logic [PH_W-1:0]       ph;
    int                    idx;
    int                    quad;
    int                    q;
    longint                s;
    longint                sv;
    longint                d;
    longint                lvl;
    prod = 64'(ts) * 64'(rate_cfg);
    ph   = PH_W'(prod[PHASE_BITS-1:0]) << (PH_W - PHASE_BITS);
    s    = ph[PH_W-1] ? longint'(ph) - (longint'(1) << PH_W) : longint'(ph);
    d    = longint'(depth_cfg);
    lvl  = 0;
    case (wave_sel)
      WAVE_SINE: begin
        idx  = int'(ph >> (PH_W - SINE_TABLE_BITS));
        quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
        q    = idx & (QUARTER_LEN - 1);
        case (quad)
          0:       sv = quarter_sine[q];
          1:       sv = quarter_sine[QUARTER_LEN - q];
          2:       sv = -quarter_sine[q];
          default: sv = -quarter_sine[QUARTER_LEN - q];
        endcase
        lvl = (d * sv) >>> SINE_FRAC;
      end
      WAVE_TRIANGLE: begin
        lvl = (d * (s < 0 ? -s : s)) >>> PH_W;
      end
      WAVE_SAWTOOTH: begin
        lvl = (d * s) >>> PH_W;
      end
      default: begin
        lvl = 0;
      end
    endcase
    return lvl[LEVEL_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!reg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (ts_queue.size() != 0 || start || levels_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0 || ts_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        start     <= 1'b1;
        timestamp <= ts_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = burst_gaps ? $urandom_range(1, 8) : 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lfo_sample_t due;
    if (rst) begin
      wave_sel     = WAVE_SINE;
      rate_cfg     = RATE_RESET;
      depth_cfg    = '0;
      item_taken   = 1'b0;
      reg_taken    = 1'b0;
      quiet_cycles = 0;
    end else begin
      item_taken = start && !busy;
      reg_taken  = cfg_valid && cfg_ready;
      if (reg_taken) begin
        case (cfg_index)
          CFG_WAVE:  wave_sel  = cfg_data[WAVE_W-1:0];
          CFG_RATE:  rate_cfg  = cfg_data[RATE_W-1:0];
          CFG_DEPTH: depth_cfg = cfg_data[DEPTH_W-1:0];
          default:   ;
        endcase
      end
      if (item_taken) begin
        due.ts    = timestamp;
        due.level = lfo_level(timestamp);
        levels_due.push_back(due);
      end
      if (done) begin
        if (levels_due.size() == 0) begin
          if (mismatches < 10) $display("tb: level %0d strobed with no item pending", level);
          mismatches++;
        end else begin
          due = levels_due.pop_front();
          if (level !== due.level) begin
            if (mismatches < 10) begin
              $display("tb: level mismatch ts=%h wave=%0d rate=%0d depth=%0d expected %0d got %0d",
                       due.ts, wave_sel, rate_cfg, depth_cfg, due.level, level);
            end
            mismatches++;
          end
        end
      end
      if (item_taken || reg_taken || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned odd_coef [5];
    longint unsigned ux;
    longint unsigned ux2;
    longint unsigned acc;
    longint unsigned v;
    logic [RATE_W-1:0]  rate_pick;
    logic [DEPTH_W-1:0] depth_pick;
    logic [TS_W-1:0]    ts_pick;

    // The quarter sine is an odd Taylor series in Q30, folded by Horner's rule.
    odd_coef = '{64'd172272, 64'd5026995, 64'd85569305, 64'd693598668, 64'd1686629713};
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      ux  = longint'(k) << (30 - (SINE_TABLE_BITS - 2));
      ux2 = (ux * ux) >> 30;
      acc = 64'd3864;
      for (int n = 0; n < 5; n++) acc = odd_coef[n] - ((acc * ux2) >> 30);
      acc = (acc * ux) >> 30;
      v   = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_sine[k] = (v > 64'd32767) ? 32767 : longint'(v);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: sine at zero depth gives silence everywhere.
    ts_queue = '{32'h0000_0000, 32'hFFFF_FFFF};
    wait_drained();

    write_reg(CFG_DEPTH, 15'h7FFF);
    ts_queue = '{32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
                 32'h0000_FFFF, 32'h0000_2000, 32'hFFFF_4000};
    wait_drained();

    // Upper data bits must be masked off; the large rate makes the product wrap.
    write_reg(CFG_WAVE, 15'h7FFD);
    write_reg(CFG_RATE, 15'h7FFF);
    ts_queue = '{32'hFFFF_FFFF, 32'h8000_0010, 32'h0000_0010, 32'h0000_0008};
    wait_drained();

    write_reg(CFG_WAVE, {13'd0, WAVE_SAWTOOTH});
    write_reg(CFG_RATE, 15'd1);
    ts_queue = '{32'h0000_8000, 32'h0000_7FFF, 32'h0000_4000, 32'h0000_0000};
    wait_drained();

    write_reg(CFG_WAVE, 15'h7FFF);
    write_reg(CFG_SPARE, 15'h5555);
    ts_queue = '{32'h0000_4000};
    wait_drained();

    write_reg(CFG_WAVE, {13'd0, WAVE_SINE});
    write_reg(CFG_RATE, 15'd0);
    ts_queue = '{32'h0000_4000, 32'hFFFF_FFFF};
    wait_drained();

    repeat (RANDOM_PHASES) begin
      case ($urandom_range(0, 5))
        0:       rate_pick = '0;
        1:       rate_pick = 12'd1;
        2:       rate_pick = '1;
        default: rate_pick = RATE_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       depth_pick = '0;
        1:       depth_pick = 15'd1;
        2:       depth_pick = '1;
        default: depth_pick = DEPTH_W'($urandom);
      endcase
      write_reg(CFG_WAVE, {13'($urandom),
                           ($urandom_range(0, 9) == 0) ? WAVE_UNUSED : WAVE_W'($urandom_range(0, 2))});
      write_reg(CFG_RATE, {3'($urandom), rate_pick});
      write_reg(CFG_DEPTH, depth_pick);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
      burst_gaps = $urandom_range(0, 3) != 0;
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 6))
          0:       ts_pick = $urandom_range(0, 65535);
          1:       ts_pick = {16'($urandom), 16'h8000};
          2:       ts_pick = {16'($urandom), 16'hFFFF};
          3:       ts_pick = {16'($urandom), 2'($urandom), 14'd0};
          default: ts_pick = $urandom;
        endcase
        ts_queue.push_back(ts_pick);
      end
      wait_drained();
    end

    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
